@@ sv/occurrence_threshold_budget_assert.svh @@
// assertion macros shared by the checker
`ifndef OCCURRENCE_THRESHOLD_BUDGET_ASSERT_SVH
`define OCCURRENCE_THRESHOLD_BUDGET_ASSERT_SVH

// same-cycle implication, sampled on clk, off during reset
`define OTB_ASSERT_NOW(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define OTB_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

@@ sv/otb_pkg.sv @@
`default_nettype none

package otb_pkg;

    localparam int OCC_W    = 32;
    localparam int BUDGET_W = 48;
    localparam int THR_W    = 63;
    localparam int PROD_W   = 2 * OCC_W;
    localparam int BOUND_W  = OCC_W + 1;

    // budget plus rounding term needs one more bit
    localparam int DIV_W    = BUDGET_W + 1;

    localparam int HIT_RECORD_BYTES_DEF = 24;

    localparam int APB_AW = 5;
    localparam int APB_DW = 64;
    localparam int REG_IDX_W = 2;

    localparam logic [REG_IDX_W-1:0] REG_MIN_OCC = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_MAX_OCC = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_BUDGET  = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_USER    = 2'd3;

    localparam logic [THR_W-1:0] UNLIMITED = {THR_W{1'b1}};

    typedef struct packed {
        logic [OCC_W-1:0]    min_occ;
        logic [OCC_W-1:0]    max_occ;
        logic [BUDGET_W-1:0] budget;
        logic [OCC_W-1:0]    user_thr;
    } cfg_t;

endpackage

`default_nettype wire

@@ sv/occurrence_threshold_budget.sv @@
// Occurrence threshold under a byte budget for seed hits. Histogram bins
// arrive one word per cycle on s_axis, in ascending occurrence order, with
// s_axis_tlast on the final bin; a bin is taken every cycle while the output
// is free and no limit is being computed. Each bin goes through an input
// register, one multiply with an add/compare against the running hit total,
// and a result register, so the threshold for a histogram shows on m_axis
// once its last bin has passed both registers, and only last bins produce a
// word. Writing memory_budget_bytes starts a reciprocal multiplication that
// works out ceil(budget / record size) from four half-width partial
// products, one per cycle; s_axis_tready stays low while it runs. Registers
// sit on the APB port at 8-byte spacing:
// min_occurrence, max_occurrence, memory_budget_bytes, user_threshold.
`default_nettype none

module occurrence_threshold_budget
    import otb_pkg::*;
#(
    parameter int HIT_RECORD_BYTES = HIT_RECORD_BYTES_DEF
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,

    input  wire logic              s_axis_tvalid,
    output logic                   s_axis_tready,
    input  wire logic [63:0]       s_axis_tdata,  // bin_occurrence, bin_seed_count
    input  wire logic              s_axis_tlast,  // last_bin

    output logic                   m_axis_tvalid,
    input  wire logic              m_axis_tready,
    output logic [63:0]            m_axis_tdata,  // threshold, one zero pad bit

    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    output logic [APB_DW-1:0]      prdata,
    output logic                   pready
);

    cfg_t                 cfg_reg;
    cfg_t                 cfg_next;
    logic                 cfg_wr;
    logic [REG_IDX_W-1:0] reg_idx;

    logic                 div_busy;
    logic [BUDGET_W-1:0]  limit;

    logic                 in_valid_reg;
    logic                 in_valid_next;
    logic [OCC_W-1:0]     in_occ_reg;
    logic [OCC_W-1:0]     in_cnt_reg;
    logic                 in_last_reg;

    logic                 out_valid_reg;
    logic                 out_valid_next;
    logic [THR_W-1:0]     out_thr_reg;
    logic [THR_W-1:0]     threshold;

    logic                 pipe_en;
    logic                 in_take;

    assign pready  = 1'b1;
    assign reg_idx = paddr[APB_AW-1:APB_AW-REG_IDX_W];
    assign cfg_wr  = psel && penable && pwrite && pready;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_wr)
        begin
            case (reg_idx)
                REG_MIN_OCC: cfg_next.min_occ  = pwdata[OCC_W-1:0];
                REG_MAX_OCC: cfg_next.max_occ  = pwdata[OCC_W-1:0];
                REG_BUDGET:  cfg_next.budget   = pwdata[BUDGET_W-1:0];
                REG_USER:    cfg_next.user_thr = pwdata[OCC_W-1:0];
                default:     cfg_next = cfg_reg;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            REG_MIN_OCC: prdata = APB_DW'(cfg_reg.min_occ);
            REG_MAX_OCC: prdata = APB_DW'(cfg_reg.max_occ);
            REG_BUDGET:  prdata = APB_DW'(cfg_reg.budget);
            REG_USER:    prdata = APB_DW'(cfg_reg.user_thr);
            default:     prdata = '0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    otb_limit_div #(
        .HIT_RECORD_BYTES (HIT_RECORD_BYTES)
    ) u_limit_div (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (cfg_wr && (reg_idx == REG_BUDGET)),
        .budget (pwdata[BUDGET_W-1:0]),
        .busy   (div_busy),
        .limit  (limit)
    );

    // the whole pipe moves when the result register is free or being drained
    assign pipe_en       = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = pipe_en && !div_busy;
    assign in_take       = s_axis_tvalid && s_axis_tready;

    assign in_valid_next  = pipe_en ? in_take : in_valid_reg;
    assign out_valid_next = pipe_en ? (in_valid_reg && in_last_reg) : out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            in_occ_reg  <= s_axis_tdata[OCC_W-1:0];
            in_cnt_reg  <= s_axis_tdata[2*OCC_W-1:OCC_W];
            in_last_reg <= s_axis_tlast;
        end
        if (pipe_en && in_valid_reg && in_last_reg)
        begin
            out_thr_reg <= threshold;
        end
    end

    otb_walk u_walk (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en && in_valid_reg),
        .occ       (in_occ_reg),
        .seed_cnt  (in_cnt_reg),
        .last      (in_last_reg),
        .cfg       (cfg_reg),
        .limit     (limit),
        .threshold (threshold)
    );

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_thr_reg};

endmodule

`default_nettype wire

@@ sv/otb_limit_div.sv @@
`default_nettype none

module otb_limit_div
    import otb_pkg::*;
#(
    parameter int HIT_RECORD_BYTES = HIT_RECORD_BYTES_DEF
)
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                start,
    input  wire logic [BUDGET_W-1:0] budget,
    output logic                     busy,
    output logic [BUDGET_W-1:0]      limit
);

    // ceil(budget / record size) = (x * RECIP) >> SHIFT with x = budget + record size - 1;
    // RECIP = ceil(2^SHIFT / record size) is exact for every x below 2^DIV_W
    localparam int HALF_W  = (DIV_W + 1) / 2;
    localparam int RECIP_W = 2 * HALF_W;
    localparam int SHIFT   = DIV_W + $clog2(HIT_RECORD_BYTES);
    localparam int ACC_W   = SHIFT + BUDGET_W;
    localparam logic [63:0] RECIP_FULL =
        ((64'd1 << SHIFT) + 64'(HIT_RECORD_BYTES) - 64'd1) / 64'(HIT_RECORD_BYTES);
    localparam logic [HALF_W-1:0] RECIP_LO = RECIP_FULL[HALF_W-1:0];
    localparam logic [HALF_W-1:0] RECIP_HI = RECIP_FULL[RECIP_W-1:HALF_W];
    localparam logic [DIV_W-1:0]  ROUND    = DIV_W'(HIT_RECORD_BYTES - 1);
    localparam logic [1:0]        LAST_STEP = 2'd3;

    logic [DIV_W-1:0]   x_reg;
    logic [DIV_W-1:0]   x_next;
    logic [ACC_W-1:0]   acc_reg;
    logic [ACC_W-1:0]   acc_next;
    logic [1:0]         step_reg;
    logic [1:0]         step_next;
    logic               busy_reg;
    logic               busy_next;
    logic [HALF_W-1:0]  mul_a;
    logic [HALF_W-1:0]  mul_b;
    logic [RECIP_W-1:0] pp;
    logic [ACC_W-1:0]   pp_ext;
    logic [ACC_W-1:0]   term_a;
    logic [ACC_W-1:0]   term;

    // one half by half partial product per cycle, low halves first
    assign mul_a  = step_reg[1] ? HALF_W'(x_reg[DIV_W-1:HALF_W]) : x_reg[HALF_W-1:0];
    assign mul_b  = step_reg[0] ? RECIP_HI : RECIP_LO;
    assign pp     = RECIP_W'(mul_a) * RECIP_W'(mul_b);
    assign pp_ext = ACC_W'(pp);
    assign term_a = step_reg[1] ? (pp_ext << HALF_W) : pp_ext;
    assign term   = step_reg[0] ? (term_a << HALF_W) : term_a;

    always_comb
    begin
        x_next    = x_reg;
        acc_next  = acc_reg;
        step_next = step_reg;
        busy_next = busy_reg;
        if (start)
        begin
            x_next    = {1'b0, budget} + ROUND;
            acc_next  = '0;
            step_next = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            acc_next  = acc_reg + term;
            step_next = step_reg + 2'd1;
            if (step_reg == LAST_STEP)
            begin
                busy_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            x_reg    <= '0;
            acc_reg  <= '0;
            step_reg <= '0;
            busy_reg <= 1'b0;
        end
        else
        begin
            x_reg    <= x_next;
            acc_reg  <= acc_next;
            step_reg <= step_next;
            busy_reg <= busy_next;
        end
    end

    assign busy  = busy_reg;
    assign limit = acc_reg[ACC_W-1:SHIFT];

endmodule

`default_nettype wire

@@ sv/otb_walk.sv @@
`default_nettype none

module otb_walk
    import otb_pkg::*;
(
    input  wire logic                clk,
    input  wire logic                rst_n,
    input  wire logic                en,
    input  wire logic [OCC_W-1:0]    occ,
    input  wire logic [OCC_W-1:0]    seed_cnt,
    input  wire logic                last,
    input  wire cfg_t                cfg,
    input  wire logic [BUDGET_W-1:0] limit,
    output logic [THR_W-1:0]         threshold
);

    logic [BUDGET_W-1:0] hits_reg;
    logic [BUDGET_W-1:0] hits_next;
    logic                reached_reg;
    logic                reached_next;
    logic [THR_W-1:0]    bound_reg;
    logic [THR_W-1:0]    bound_next;

    logic [PROD_W-1:0]   prod;
    logic [BUDGET_W-1:0] room;
    logic                over;
    logic                active;
    logic                take;
    logic [BOUND_W-1:0]  occ_plus;
    logic [THR_W-1:0]    bound_take;
    logic [THR_W-1:0]    cap;
    logic [THR_W-1:0]    usr;
    logic [THR_W-1:0]    min_ext;
    logic [THR_W-1:0]    cap_usr;
    logic [THR_W-1:0]    take_min;
    logic [THR_W-1:0]    keep_min;
    logic [THR_W-1:0]    thr_take;
    logic [THR_W-1:0]    thr_keep;

    assign prod       = PROD_W'(occ) * PROD_W'(seed_cnt);
    assign room       = limit - hits_reg;
    assign over       = (hits_reg > limit) || (prod > PROD_W'(room));
    assign active     = (cfg.budget != '0) && !reached_reg;
    assign take       = active && !over;
    assign occ_plus   = BOUND_W'(occ) + BOUND_W'(1);
    assign bound_take = THR_W'(occ_plus);

    assign cap     = (cfg.max_occ != '0) ? THR_W'(cfg.max_occ) : UNLIMITED;
    assign usr     = (cfg.user_thr != '0) ? THR_W'(cfg.user_thr) : UNLIMITED;
    assign min_ext = THR_W'(cfg.min_occ);
    assign cap_usr = (cap < usr) ? cap : usr;

    // threshold for a bin that sets the bound and for one that leaves it
    assign take_min = (bound_take < cap_usr) ? bound_take : cap_usr;
    assign keep_min = (bound_reg < cap_usr) ? bound_reg : cap_usr;
    assign thr_take = (min_ext > take_min) ? min_ext : take_min;
    assign thr_keep = (min_ext > keep_min) ? min_ext : keep_min;

    assign threshold = take ? thr_take : thr_keep;

    always_comb
    begin
        hits_next    = hits_reg;
        reached_next = reached_reg;
        bound_next   = bound_reg;
        if (en)
        begin
            if (last)
            begin
                hits_next    = '0;
                reached_next = 1'b0;
                bound_next   = UNLIMITED;
            end
            else if (active)
            begin
                if (over)
                begin
                    reached_next = 1'b1;
                end
                else
                begin
                    hits_next  = hits_reg + prod[BUDGET_W-1:0];
                    bound_next = bound_take;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hits_reg    <= '0;
            reached_reg <= 1'b0;
            bound_reg   <= UNLIMITED;
        end
        else
        begin
            hits_reg    <= hits_next;
            reached_reg <= reached_next;
            bound_reg   <= bound_next;
        end
    end

endmodule

`default_nettype wire

@@ sv/otb_checker.sv @@
`default_nettype none

`include "occurrence_threshold_budget_assert.svh"

module otb_checker
    import otb_pkg::*;
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              s_axis_tvalid,
    input  wire logic              s_axis_tready,
    input  wire logic [63:0]       s_axis_tdata,
    input  wire logic              s_axis_tlast,
    input  wire logic              m_axis_tvalid,
    input  wire logic              m_axis_tready,
    input  wire logic [63:0]       m_axis_tdata,
    input  wire logic              psel,
    input  wire logic              penable,
    input  wire logic              pwrite,
    input  wire logic [APB_AW-1:0] paddr,
    input  wire logic [APB_DW-1:0] pwdata,
    input  wire logic [APB_DW-1:0] prdata,
    input  wire logic              pready
);

    logic budget_wr;

    assign budget_wr = psel && penable && pwrite && pready
                       && (paddr[APB_AW-1:APB_AW-REG_IDX_W] == REG_BUDGET);

    `OTB_ASSERT_NEXT(a_out_hold, m_axis_tvalid && !m_axis_tready, m_axis_tvalid, "result word dropped while stalled")
    `OTB_ASSERT_NEXT(a_out_stable, m_axis_tvalid && !m_axis_tready, $stable(m_axis_tdata), "result word changed while stalled")
    `OTB_ASSERT_NOW(a_out_pad, m_axis_tvalid, m_axis_tdata[63] == 1'b0, "threshold pad bit set")
    `OTB_ASSERT_NEXT(a_div_block, budget_wr, !s_axis_tready, "bins taken while limit is being computed")

endmodule

bind occurrence_threshold_budget otb_checker u_otb_checker (.*);

`default_nettype wire

@@ bench/tb_top.sv @@
`default_nettype none

module tb_top;
    import otb_pkg::*;

    localparam logic [63:0] REC_BYTES      = 64'(HIT_RECORD_BYTES_DEF);
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam int          SETTLE_CYCLES  = 8;

    typedef struct {
        logic [OCC_W-1:0] occ;
        logic [OCC_W-1:0] cnt;
        logic             last;
    } bin_t;

    logic              clk = 1'b0;
    logic              rst_n = 1'b0;

    logic              s_axis_tvalid = 1'b0;
    logic              s_axis_tready;
    logic [63:0]       s_axis_tdata = '0;   // bin_occurrence, bin_seed_count
    logic              s_axis_tlast = 1'b0; // last_bin

    logic              m_axis_tvalid;
    logic              m_axis_tready = 1'b0;
    logic [63:0]       m_axis_tdata;        // threshold, one zero pad bit

    logic              psel = 1'b0;
    logic              penable = 1'b0;
    logic              pwrite = 1'b0;
    logic [APB_AW-1:0] paddr = '0;
    logic [APB_DW-1:0] pwdata = '0;
    logic [APB_DW-1:0] prdata;
    logic              pready;

    // predictor copy of registers and walk state
    logic [OCC_W-1:0]    cfg_min;
    logic [OCC_W-1:0]    cfg_max;
    logic [BUDGET_W-1:0] cfg_budget;
    logic [OCC_W-1:0]    cfg_user;
    logic [BUDGET_W-1:0] hits_total;
    logic                budget_hit;
    logic [THR_W-1:0]    mem_bound;

    bin_t             pending_bins[$];
    logic [THR_W-1:0] threshold_q[$];
    bin_t             next_bin;
    logic [THR_W-1:0] want_thr;

    int send_idle_pct;
    int recv_stall_pct;
    int error_count;
    int bins_taken;
    int results_checked;
    int idle_cycles;
    int budget_writes;

    occurrence_threshold_budget i_dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tlast  (s_axis_tlast),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready)
    );

    initial
    begin
        forever #6 clk = ~clk;
    end

    task automatic report_mismatch(input string what, input logic [THR_W-1:0] got,
                                   input logic [THR_W-1:0] want);
        error_count++;
        $display("mismatch: %s got 0x%016h want 0x%016h", what, got, want);
    endtask

    task automatic clear_walk();
        hits_total = '0;
        budget_hit = 1'b0;
        mem_bound  = UNLIMITED;
    endtask

    // one bin through the budget walk; last bin yields the threshold
    task automatic apply_bin(input logic [OCC_W-1:0] occ, input logic [OCC_W-1:0] cnt,
                             input logic last);
        logic [63:0]      hit_limit;
        logic [63:0]      prod;
        logic [THR_W-1:0] cap;
        logic [THR_W-1:0] usr;
        logic [THR_W-1:0] thr;
        if (cfg_budget != '0 && !budget_hit)
        begin
            hit_limit = ({16'd0, cfg_budget} + REC_BYTES - 64'd1) / REC_BYTES;
            prod      = {32'd0, occ} * {32'd0, cnt};
            if ({16'd0, hits_total} > hit_limit || prod > hit_limit - {16'd0, hits_total})
                budget_hit = 1'b1;
            else
            begin
                hits_total = hits_total + prod[BUDGET_W-1:0];
                mem_bound  = {31'd0, occ} + 63'd1;
            end
        end
        if (last)
        begin
            cap = (cfg_max != '0) ? {31'd0, cfg_max} : UNLIMITED;
            usr = (cfg_user != '0) ? {31'd0, cfg_user} : UNLIMITED;
            thr = (cap < mem_bound) ? cap : mem_bound;
            if (usr < thr)
                thr = usr;
            if ({31'd0, cfg_min} > thr)
                thr = {31'd0, cfg_min};
            threshold_q.push_back(thr);
            clear_walk();
        end
    endtask

    task automatic write_reg(input logic [REG_IDX_W-1:0] idx, input logic [63:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 3'b000};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        case (idx)
            REG_MIN_OCC: cfg_min = value[OCC_W-1:0];
            REG_MAX_OCC: cfg_max = value[OCC_W-1:0];
            REG_BUDGET:
            begin
                cfg_budget = value[BUDGET_W-1:0];
                budget_writes++;
            end
            REG_USER:    cfg_user = value[OCC_W-1:0];
            default:     ;
        endcase
    endtask

    task automatic push_bin(input logic [OCC_W-1:0] occ, input logic [OCC_W-1:0] cnt,
                            input logic last);
        bin_t b;
        b.occ  = occ;
        b.cnt  = cnt;
        b.last = last;
        pending_bins.push_back(b);
    endtask

    // all words sent, all thresholds back, pipeline given time to empty
    task automatic drain();
        @(negedge clk);
        while (pending_bins.size() != 0 || s_axis_tvalid)
            @(negedge clk);
        while (threshold_q.size() != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(negedge clk);
    endtask

    function automatic logic [OCC_W-1:0] pick_limit(input bit lean_zero);
        case ($urandom_range(0, lean_zero ? 7 : 5))
            0:       return 32'hFFFF_FFFF;
            1:       return 32'($urandom_range(1, 20));
            2:       return 32'($urandom_range(1, 2000));
            3:       return $urandom;
            default: return '0;
        endcase
    endfunction

    function automatic logic [BUDGET_W-1:0] pick_budget();
        case ($urandom_range(0, 6))
            0:       return '0;
            1:       return {BUDGET_W{1'b1}};
            2:       return 48'($urandom_range(1, 100));
            3:       return 48'({$urandom, $urandom});
            default: return 48'($urandom_range(1, 200000));
        endcase
    endfunction

    task automatic random_setting();
        write_reg(REG_MIN_OCC, 64'(pick_limit(1'b1)));
        write_reg(REG_MAX_OCC, 64'(pick_limit(1'b0)));
        write_reg(REG_BUDGET, 64'(pick_budget()));
        write_reg(REG_USER, 64'(pick_limit(1'b0)));
    endtask

    // mostly ascending histograms with modest products, some raw noise
    task automatic random_histograms(input int count);
        int               queued;
        int               nbins;
        logic [OCC_W-1:0] occ;
        queued = 0;
        while (queued < count)
        begin
            nbins = $urandom_range(1, 10);
            occ   = $urandom_range(0, 10);
            for (int k = 0; k < nbins; k++)
            begin
                if ($urandom_range(0, 7) == 0)
                    push_bin($urandom, $urandom, k == nbins - 1);
                else
                    push_bin(occ, $urandom_range(0, 300), k == nbins - 1);
                occ = occ + $urandom_range(0, 5);
            end
            queued += nbins;
        end
    endtask

    // driver
    always @(posedge clk)
    begin
        if (!rst_n)
            s_axis_tvalid <= 1'b0;
        else if (!s_axis_tvalid || s_axis_tready)
        begin
            if (pending_bins.size() != 0 && $urandom_range(0, 99) >= send_idle_pct)
            begin
                next_bin = pending_bins.pop_front();
                s_axis_tvalid <= 1'b1;
                s_axis_tdata  <= {next_bin.cnt, next_bin.occ};
                s_axis_tlast  <= next_bin.last;
            end
            else
                s_axis_tvalid <= 1'b0;
        end
    end

    // receiver
    always @(posedge clk)
    begin
        if (!rst_n)
            m_axis_tready <= 1'b0;
        else
            m_axis_tready <= ($urandom_range(0, 99) >= recv_stall_pct);
    end

    // monitor, checker and watchdog
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                if (threshold_q.size() == 0)
                    report_mismatch("threshold with none pending", m_axis_tdata[THR_W-1:0], '0);
                else
                begin
                    want_thr = threshold_q.pop_front();
                    results_checked++;
                    if (m_axis_tdata[THR_W-1:0] !== want_thr)
                        report_mismatch("threshold", m_axis_tdata[THR_W-1:0], want_thr);
                end
            end
            if (s_axis_tvalid && s_axis_tready)
            begin
                apply_bin(s_axis_tdata[31:0], s_axis_tdata[63:32], s_axis_tlast);
                bins_taken++;
            end
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || psel)
                idle_cycles = 0;
            else
                idle_cycles++;
            if (idle_cycles >= WATCHDOG_LIMIT)
            begin
                $display("watchdog: no word moved for %0d cycles", WATCHDOG_LIMIT);
                $display("FAILURE");
                $finish;
            end
        end
    end

    initial
    begin
        cfg_min = '0;
        cfg_max = '0;
        cfg_budget = '0;
        cfg_user = '0;
        clear_walk();
        error_count = 0;
        bins_taken = 0;
        results_checked = 0;
        idle_cycles = 0;
        budget_writes = 0;
        send_idle_pct = 22;
        recv_stall_pct = 49;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // no limits at all: extremes of both fields
        write_reg(REG_MIN_OCC, 64'd0);
        write_reg(REG_MAX_OCC, 64'd0);
        write_reg(REG_BUDGET, 64'd0);
        write_reg(REG_USER, 64'd0);
        push_bin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_bin(32'd0, 32'd0, 1'b1);
        drain();

        // hit limit of 100: exact fill, then overflow, then ignored bins
        write_reg(REG_MIN_OCC, 64'd5);
        write_reg(REG_BUDGET, 64'd2400);
        push_bin(32'd1, 32'd10, 1'b0);
        push_bin(32'd3, 32'd20, 1'b0);
        push_bin(32'd5, 32'd6, 1'b0);
        push_bin(32'd6, 32'd1, 1'b0);
        push_bin(32'd7, 32'd0, 1'b0);
        push_bin(32'd9, 32'd0, 1'b1);
        push_bin(32'd0, 32'd0, 1'b1);
        push_bin(32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1);
        push_bin(32'hFFFF_FFFF, 32'd0, 1'b1);

        // budget shrinks below the running total mid histogram
        push_bin(32'd2, 32'd50, 1'b0);
        drain();
        write_reg(REG_MIN_OCC, 64'd0);
        write_reg(REG_BUDGET, 64'd24);
        push_bin(32'd4, 32'd0, 1'b1);
        drain();

        // full budget, user cap below max cap, min clamp at top
        write_reg(REG_MIN_OCC, 64'hFFFF_FFFF);
        write_reg(REG_MAX_OCC, 64'd7);
        write_reg(REG_BUDGET, 64'hFFFF_FFFF_FFFF);
        write_reg(REG_USER, 64'd3);
        push_bin(32'd10, 32'd10, 1'b1);
        drain();
        write_reg(REG_MIN_OCC, 64'd0);
        push_bin(32'd1, 32'd1, 1'b1);
        push_bin(32'h0000_FFFF, 32'h0000_FFFF, 1'b0);
        push_bin(32'hFFFF_FFFF, 32'h0000_FFFF, 1'b1);
        drain();
        write_reg(REG_MAX_OCC, 64'hFFFF_FFFF);
        write_reg(REG_USER, 64'hFFFF_FFFF);
        push_bin(32'hFFFF_FFFF, 32'd1, 1'b1);
        drain();

        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    send_idle_pct = 22;
                    recv_stall_pct = 49;
                end
                1:
                begin
                    send_idle_pct = 49;
                    recv_stall_pct = 22;
                end
                default:
                begin
                    send_idle_pct = 0;
                    recv_stall_pct = 0;
                end
            endcase
            for (int seg = 0; seg < 4; seg++)
            begin
                random_setting();
                random_histograms(115);
                drain();
            end
        end

        repeat (20) @(negedge clk);
        $display("covered %0d bins and %0d thresholds over %0d budget settings,",
                 bins_taken, results_checked, budget_writes);
        $display("with budget overflow, mid-histogram budget change and all clamp paths");
        if (error_count == 0 && threshold_q.size() == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

endmodule

`default_nettype wire
